// ===== rtl/sync_length_frame_deframer_dedup_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_DEDUP_UNIT_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_DEDUP_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SLDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("deframer assertion failed");
`define SLDD_NEVER(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("deframer forbidden condition");
`else
`define SLDD_ASSERT(lbl, prop)
`define SLDD_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/sldd_pkg.sv =====
// ----------------------------------------------------------------------------
// Deframer package
// Item codes, result codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package sldd_pkg;

    typedef enum logic [1:0] {
        OP_PAYLOAD = 2'd0,
        OP_DONE    = 2'd1,
        OP_REJECT  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_REJECT  = 2'd2;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam logic REG_MIN_LEN = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    localparam int MAX_TAG_BYTES = 16;

    localparam logic [23:0] ID_PATTERN   = 24'h00EE00;
    localparam logic [4:0]  HEADER_BYTES = 5'd4;
    localparam logic [4:0]  OVERHEAD     = 5'd6;
    localparam logic [4:0]  FLOOR_LENGTH = 5'd8;

    // num: tag index for payload, tag length for done
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic [4:0] num;
    } entry_t;

endpackage

// ===== rtl/sldd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sldd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/sldd_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer item queue
// Four-entry queue between the parser and the tag unit.
// ----------------------------------------------------------------------------
module sldd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sldd_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sldd_pkg::entry_t head_entry
);
    sldd_pkg::entry_t buf_reg [4];
    logic [1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full       = (cnt_reg == 3'd4);
    assign head_valid = (cnt_reg != 3'd0);
    assign head_entry = buf_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? wr_reg + 2'd1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'b0, do_push} - {2'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_reg] <= push_entry;
        end
    end
endmodule

// ===== rtl/sldd_front.sv =====
// ----------------------------------------------------------------------------
// Deframer parser
// Header search over a byte window, length check and in-frame byte sorting.
// ----------------------------------------------------------------------------
module sldd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [7:0]       s_data_byte,
    input  logic [4:0]       min_len,
    input  logic [4:0]       max_len,
    output logic             q_push,
    output sldd_pkg::entry_t q_entry,
    input  logic             q_full
);
    localparam logic [8:0] CAP = 9'(sldd_pkg::MAX_TAG_BYTES + 6);

    logic [31:0] win_reg, win_next;
    logic [2:0]  wcnt_reg, wcnt_next;
    logic        in_frame_reg, in_frame_next;
    logic [4:0]  pos_reg, pos_next;
    logic [4:0]  total_reg, total_next;

    logic        accept;
    logic [31:0] win_sh;
    logic [2:0]  wcnt_inc;
    logic [8:0]  len9, hi9;
    logic [4:0]  lo5, hi5;
    logic        len_ok, hdr;
    logic [5:0]  off6, tot6;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        win_sh   = {win_reg[23:0], s_data_byte};
        wcnt_inc = (wcnt_reg < 3'd4) ? wcnt_reg + 3'd1 : wcnt_reg;
        hdr      = (wcnt_inc == 3'd4) && (win_sh[23:0] == sldd_pkg::ID_PATTERN);
        len9     = {1'b0, win_sh[31:24]} + 9'd1;
        lo5      = (min_len < sldd_pkg::FLOOR_LENGTH) ? sldd_pkg::FLOOR_LENGTH : min_len;
        hi5      = (max_len < lo5) ? lo5 : max_len;
        hi9      = ({4'b0, hi5} > CAP) ? CAP : {4'b0, hi5};
        len_ok   = (len9 >= {4'b0, lo5}) && (len9 <= hi9);
        off6     = {1'b0, pos_reg};
        tot6     = {1'b0, total_reg};

        win_next      = win_reg;
        wcnt_next     = wcnt_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        q_push        = 1'b0;
        q_entry.op    = sldd_pkg::OP_CLEAR;
        q_entry.data  = s_data_byte;
        q_entry.last  = (off6 + 6'd3 == tot6);
        q_entry.num   = pos_reg - sldd_pkg::HEADER_BYTES;

        if (accept) begin
            if (s_action == sldd_pkg::ACT_START) begin
                q_push        = 1'b1;
                win_next      = 32'd0;
                wcnt_next     = 3'd0;
                in_frame_next = 1'b0;
                pos_next      = 5'd0;
                total_next    = 5'd0;
            end else if (in_frame_reg) begin
                pos_next = pos_reg + 5'd1;
                if (off6 + 6'd3 <= tot6) begin
                    q_push     = 1'b1;
                    q_entry.op = sldd_pkg::OP_PAYLOAD;
                end else if (off6 + 6'd1 >= tot6) begin
                    q_push        = 1'b1;
                    q_entry.op    = sldd_pkg::OP_DONE;
                    q_entry.num   = total_reg - sldd_pkg::OVERHEAD;
                    win_next      = 32'd0;
                    wcnt_next     = 3'd0;
                    in_frame_next = 1'b0;
                    pos_next      = 5'd0;
                    total_next    = 5'd0;
                end
            end else begin
                win_next  = win_sh;
                wcnt_next = wcnt_inc;
                if (hdr) begin
                    if (len_ok) begin
                        in_frame_next = 1'b1;
                        pos_next      = sldd_pkg::HEADER_BYTES;
                        total_next    = len9[4:0];
                        win_next      = 32'd0;
                        wcnt_next     = 3'd0;
                    end else begin
                        win_next   = {8'd0, win_sh[23:0]};
                        wcnt_next  = 3'd3;
                        q_push     = 1'b1;
                        q_entry.op = sldd_pkg::OP_REJECT;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= 32'd0;
            wcnt_reg     <= 3'd0;
            in_frame_reg <= 1'b0;
            pos_reg      <= 5'd0;
            total_reg    <= 5'd0;
        end else begin
            win_reg      <= win_next;
            wcnt_reg     <= wcnt_next;
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
        end
    end
endmodule

// ===== rtl/sldd_back.sv =====
// ----------------------------------------------------------------------------
// Deframer tag unit
// Collects the tag, walks the seen table at frame end and drives results.
// ----------------------------------------------------------------------------
module sldd_back #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  sldd_pkg::entry_t q_entry,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_event_res,
    output logic [7:0]       m_payload_byte,
    output logic             m_payload_last,
    output logic             m_duplicate,
    output logic [4:0]       m_tag_slot,
    output logic             m_table_full
);
    localparam int TAG_BYTES = sldd_pkg::MAX_TAG_BYTES;
    localparam int IW = $clog2(TAG_BYTES);
    localparam int SD = TABLE_ENTRIES * TAG_BYTES;
    localparam int AW = $clog2(SD);
    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] TE_C = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] STRIDE = AW'(TAG_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LEN   = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0]    tag_reg [TAG_BYTES];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] s_reg, s_next;
    logic [AW-1:0] base_reg, base_next;
    logic [4:0]    j_reg, j_next;
    logic [4:0]    tlen_reg, tlen_next;

    logic       ov_reg, ov_next, full_reg, full_next, last_reg, last_next, dup_reg, dup_next;
    logic [1:0] ev_reg, ev_next;
    logic [7:0] pb_reg, pb_next;
    logic [4:0] slot_reg, slot_next;

    logic          tag_we;
    logic          st_we, ln_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] ln_addr_w, ln_raddr;
    logic [7:0]    st_rdata;
    logic [4:0]    ln_rdata;
    logic          advance, nomatch;
    logic [4:0]    j_inc;
    logic [CW-1:0] s_inc;

    sldd_ram #(.WIDTH(8), .DEPTH(SD)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (tag_reg[j_reg[IW-1:0]]),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    sldd_ram #(.WIDTH(5), .DEPTH(TABLE_ENTRIES)) u_lens (
        .aclk  (aclk),
        .we    (ln_we),
        .waddr (ln_addr_w),
        .wdata (tlen_reg),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    assign j_inc     = j_reg + 5'd1;
    assign s_inc     = s_reg + CW'(1);
    assign st_waddr  = base_reg + AW'(j_reg);
    assign ln_addr_w = s_reg[SW-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        s_next     = s_reg;
        base_next  = base_reg;
        j_next     = j_reg;
        tlen_next  = tlen_reg;
        ov_next    = ov_reg && !m_ready;
        ev_next    = ev_reg;
        pb_next    = pb_reg;
        last_next  = last_reg;
        dup_next   = dup_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        q_pop      = 1'b0;
        tag_we     = 1'b0;
        st_we      = 1'b0;
        ln_we      = 1'b0;
        st_raddr   = base_reg;
        ln_raddr   = '0;
        advance    = 1'b0;
        nomatch    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && !ov_reg) begin
                    q_pop = 1'b1;
                    case (q_entry.op)
                        sldd_pkg::OP_PAYLOAD: begin
                            tag_we    = 1'b1;
                            ov_next   = 1'b1;
                            ev_next   = sldd_pkg::EV_PAYLOAD;
                            pb_next   = q_entry.data;
                            last_next = q_entry.last;
                            dup_next  = 1'b0;
                            slot_next = 5'd0;
                            full_next = 1'b0;
                        end
                        sldd_pkg::OP_REJECT: begin
                            ov_next   = 1'b1;
                            ev_next   = sldd_pkg::EV_REJECT;
                            pb_next   = 8'd0;
                            last_next = 1'b0;
                            dup_next  = 1'b0;
                            slot_next = 5'd0;
                            full_next = 1'b0;
                        end
                        sldd_pkg::OP_DONE: begin
                            tlen_next = q_entry.num;
                            s_next    = '0;
                            base_next = '0;
                            j_next    = 5'd0;
                            if (count_reg == '0) begin
                                nomatch = 1'b1;
                            end else begin
                                state_next = ST_LEN;
                            end
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if (ln_rdata == tlen_reg) begin
                    j_next     = 5'd0;
                    state_next = ST_CMP;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_CMP: begin
                if (st_rdata != tag_reg[j_reg[IW-1:0]]) begin
                    advance = 1'b1;
                end else if (j_inc == tlen_reg) begin
                    ov_next    = 1'b1;
                    ev_next    = sldd_pkg::EV_DONE;
                    pb_next    = 8'd0;
                    last_next  = 1'b0;
                    dup_next   = 1'b1;
                    slot_next  = 5'(s_reg);
                    full_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    j_next   = j_inc;
                    st_raddr = base_reg + AW'(j_inc);
                end
            end
            ST_WRITE: begin
                st_we  = 1'b1;
                j_next = j_inc;
                if (j_inc == tlen_reg) begin
                    ln_we      = 1'b1;
                    count_next = count_reg + CW'(1);
                    ov_next    = 1'b1;
                    ev_next    = sldd_pkg::EV_DONE;
                    pb_next    = 8'd0;
                    last_next  = 1'b0;
                    dup_next   = 1'b0;
                    slot_next  = 5'(s_reg);
                    full_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            s_next    = s_inc;
            base_next = base_reg + STRIDE;
            if (s_inc == count_reg) begin
                nomatch = 1'b1;
            end else begin
                ln_raddr   = s_inc[SW-1:0];
                state_next = ST_LEN;
            end
        end
        if (state_reg == ST_IDLE && state_next == ST_LEN) begin
            ln_raddr = '0;
        end

        if (nomatch) begin
            j_next = 5'd0;
            if (count_reg >= TE_C) begin
                ov_next    = 1'b1;
                ev_next    = sldd_pkg::EV_DONE;
                pb_next    = 8'd0;
                last_next  = 1'b0;
                dup_next   = 1'b0;
                slot_next  = 5'd0;
                full_next  = 1'b1;
                state_next = ST_IDLE;
            end else begin
                state_next = ST_WRITE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg    <= s_next;
        base_reg <= base_next;
        j_reg    <= j_next;
        tlen_reg <= tlen_next;
        ev_reg   <= ev_next;
        pb_reg   <= pb_next;
        last_reg <= last_next;
        dup_reg  <= dup_next;
        slot_reg <= slot_next;
        full_reg <= full_next;
        if (tag_we) begin
            tag_reg[q_entry.num[IW-1:0]] <= q_entry.data;
        end
    end

    assign m_valid        = ov_reg;
    assign m_event_res    = ev_reg;
    assign m_payload_byte = pb_reg;
    assign m_payload_last = last_reg;
    assign m_duplicate    = dup_reg;
    assign m_tag_slot     = slot_reg;
    assign m_table_full   = full_reg;
endmodule

// ===== rtl/sync_length_frame_deframer_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer with seen-tag table
// Parser front end, four-entry queue, tag unit with table walk at frame end.
//
//  channel  signals                                   direction
//  s_       s_valid s_ready s_action s_data_byte       in
//  m_       m_valid m_ready m_event_res ... table_full out
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data     in
//
// Parser takes an item per cycle while the queue has room.
// The tag unit holds each payload and reject result until m_ready takes
// it before it pops the next item. Frame end walks the table, checking
// each slot's stored length and, on a match, its bytes, then stores a new
// tag byte by byte (store RAM port bound). A full queue stalls s_.
// Synchronous active-low reset; tables need no clearing pass.
// ----------------------------------------------------------------------------
`include "sync_length_frame_deframer_dedup_unit_defines.svh"

module sync_length_frame_deframer_dedup_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_res,
    output logic [7:0] m_payload_byte,
    output logic       m_payload_last,
    output logic       m_duplicate,
    output logic [4:0] m_tag_slot,
    output logic       m_table_full,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data
);
    logic [4:0] min_len_reg, max_len_reg;
    logic       q_push, q_full, q_pop, q_valid;
    sldd_pkg::entry_t push_entry, head_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= 5'd8;
            max_len_reg <= 5'd22;
        end else if (cfg_valid) begin
            case (cfg_index)
                sldd_pkg::REG_MIN_LEN: min_len_reg <= cfg_data;
                sldd_pkg::REG_MAX_LEN: max_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sldd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .min_len     (min_len_reg),
        .max_len     (max_len_reg),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .q_full      (q_full)
    );

    sldd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    sldd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_entry        (head_entry),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_payload_byte (m_payload_byte),
        .m_payload_last (m_payload_last),
        .m_duplicate    (m_duplicate),
        .m_tag_slot     (m_tag_slot),
        .m_table_full   (m_table_full)
    );

    `SLDD_NEVER(a_dup_and_full, m_valid && m_duplicate && m_table_full)
    `SLDD_ASSERT(a_payload_clean, m_valid && m_event_res == sldd_pkg::EV_PAYLOAD |-> !m_duplicate && !m_table_full && m_tag_slot == 5'd0)
    `SLDD_ASSERT(a_no_push_full, q_full |-> !s_ready)
    `SLDD_ASSERT(a_pop_only_free, q_pop |-> !$past(q_pop) || !m_valid || m_event_res != sldd_pkg::EV_DONE)
endmodule

// ===== test/tb_sync_length_frame_deframer_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// Deframer with seen-tag table: testbench
// Drives received bytes and start items, predicts every result from an
// internal copy of the parser and tag table, and checks each result field.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_deframer_dedup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAG_MAX  = sldd_pkg::MAX_TAG_BYTES;
    localparam int SLOTS    = 32;
    localparam int SETTLE   = 1500;
    localparam int DOG_LIMIT = 6000;
    localparam int ITEMS_TOTAL = 1800;

    typedef struct {
        logic [1:0] ev;
        logic [7:0] pb;
        logic       last;
        logic       dup;
        logic [4:0] slot;
        logic       full;
    } frame_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_action = sldd_pkg::ACT_BYTE;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_event_res;
    logic [7:0] m_payload_byte;
    logic       m_payload_last;
    logic       m_duplicate;
    logic [4:0] m_tag_slot;
    logic       m_table_full;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = sldd_pkg::REG_MIN_LEN;
    logic [4:0] cfg_data = 5'd0;

    sync_length_frame_deframer_dedup_unit dut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    int          min_len, max_len;
    logic [31:0] window;
    int          win_cnt, frame_pos, frame_tot;
    bit          framing;
    logic [7:0]  cur_tag[TAG_MAX];
    logic [7:0]  seen_tags[SLOTS][TAG_MAX];
    int          seen_len[SLOTS];
    int          seen_cnt;

    frame_result_t expected_q[$];
    int  errors = 0;
    int  items_sent = 0;
    bit  calm = 1'b0;
    int  dog = 0;

    // tags reused for duplicate detection
    logic [7:0] pool[64][TAG_MAX];
    int         pool_len[64];
    int         pool_n = 0;

    function automatic void push(logic [1:0] ev, logic [7:0] pb, logic last, logic dup,
                                 logic [4:0] slot, logic full);
        frame_result_t r;
        r.ev = ev; r.pb = pb; r.last = last; r.dup = dup; r.slot = slot; r.full = full;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void clear_parser();
        window = 0; win_cnt = 0; framing = 0; frame_pos = 0; frame_tot = 0;
    endfunction

    function automatic void close_frame();
        int tl, s, k;
        bit same;
        tl = frame_tot - 6;
        if (tl > TAG_MAX) tl = TAG_MAX;
        for (s = 0; s < seen_cnt && s < SLOTS; s++) begin
            same = (seen_len[s] == tl);
            for (k = 0; k < tl; k++)
                if (seen_tags[s][k] != cur_tag[k]) same = 0;
            if (same) begin
                push(sldd_pkg::EV_DONE, 8'h00, 1'b0, 1'b1, s[4:0], 1'b0);
                return;
            end
        end
        if (seen_cnt >= SLOTS) begin
            push(sldd_pkg::EV_DONE, 8'h00, 1'b0, 1'b0, 5'd0, 1'b1);
            return;
        end
        for (k = 0; k < tl; k++) seen_tags[seen_cnt][k] = cur_tag[k];
        seen_len[seen_cnt] = tl;
        push(sldd_pkg::EV_DONE, 8'h00, 1'b0, 1'b0, seen_cnt[4:0], 1'b0);
        seen_cnt++;
    endfunction

    function automatic void predict(logic act, logic [7:0] b);
        int off, len, lo, hi;
        if (act == sldd_pkg::ACT_START) begin
            clear_parser();
            seen_cnt = 0;
            return;
        end
        if (framing) begin
            off = frame_pos;
            frame_pos++;
            if (off + 3 <= frame_tot) begin
                if (off - 4 < TAG_MAX) cur_tag[off - 4] = b;
                push(sldd_pkg::EV_PAYLOAD, b, off + 3 == frame_tot, 1'b0, 5'd0, 1'b0);
            end else if (off + 1 >= frame_tot) begin
                close_frame();
                clear_parser();
            end
            return;
        end
        window = {window[23:0], b};
        if (win_cnt < 4) win_cnt++;
        if (win_cnt == 4 && window[23:0] == sldd_pkg::ID_PATTERN) begin
            len = int'(window[31:24]) + 1;
            lo = (min_len < 8) ? 8 : min_len;
            hi = (max_len < lo) ? lo : max_len;
            if (hi > TAG_MAX + 6) hi = TAG_MAX + 6;
            if (len >= lo && len <= hi) begin
                framing = 1; frame_pos = 4; frame_tot = len;
                window = 0; win_cnt = 0;
            end else begin
                window[31:24] = 8'h00;
                win_cnt = 3;
                push(sldd_pkg::EV_REJECT, 8'h00, 1'b0, 1'b0, 5'd0, 1'b0);
            end
        end
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send(logic act, logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict(act, b);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == sldd_pkg::REG_MIN_LEN) min_len = int'(val); else max_len = int'(val);
    endtask

    task automatic send_header(logic [7:0] l);
        send(sldd_pkg::ACT_BYTE, l);
        send(sldd_pkg::ACT_BYTE, 8'h00);
        send(sldd_pkg::ACT_BYTE, 8'hEE);
        send(sldd_pkg::ACT_BYTE, 8'h00);
    endtask

    // frame with tag taken from the pool slot p (new random tag if p < 0)
    task automatic send_frame(int tl, int p);
        logic [7:0] t[TAG_MAX];
        int k;
        if (p >= 0) begin
            tl = pool_len[p];
            t = pool[p];
        end else begin
            for (k = 0; k < TAG_MAX; k++) t[k] = 8'($urandom_range(0, 255));
            if (pool_n < 64) begin
                pool[pool_n] = t; pool_len[pool_n] = tl; pool_n++;
            end
        end
        send_header(8'(tl + 5));
        for (k = 0; k < tl; k++) send(sldd_pkg::ACT_BYTE, t[k]);
        send(sldd_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        send(sldd_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic random_frame();
        if (pool_n > 0 && $urandom_range(0, 9) < 3)
            send_frame(0, $urandom_range(0, pool_n - 1));
        else
            send_frame($urandom_range(2, TAG_MAX), -1);
    endtask

    task automatic test_directed();
        send(sldd_pkg::ACT_START, 8'hFF);
        send_frame(2, -1);
        send_frame(TAG_MAX, -1);
        send_frame(0, 0);
        send_header(8'hFF);
        send_header(8'h00);
        send(sldd_pkg::ACT_BYTE, 8'hEE);
        send(sldd_pkg::ACT_BYTE, 8'h00);
        send_header(8'd9);
        send(sldd_pkg::ACT_BYTE, 8'hA5);
        send(sldd_pkg::ACT_START, 8'h00);
        send_frame(0, 1);
        drain();
    endtask

    task automatic test_bounds();
        int mins[6] = '{0, 22, 31, 12, 8, 31};
        int maxs[6] = '{31, 8, 31, 14, 22, 0};
        int i, j;
        for (i = 0; i < 6; i++) begin
            write_reg(sldd_pkg::REG_MIN_LEN, 5'(mins[i]));
            write_reg(sldd_pkg::REG_MAX_LEN, 5'(maxs[i]));
            for (j = 0; j < 6; j++) random_frame();
            send_header(8'($urandom_range(0, 255)));
            drain();
        end
        write_reg(sldd_pkg::REG_MIN_LEN, 5'd8);
        write_reg(sldd_pkg::REG_MAX_LEN, 5'd22);
    endtask

    task automatic test_table_full();
        int j;
        send(sldd_pkg::ACT_START, 8'h00);
        for (j = 0; j < SLOTS + 5; j++) send_frame($urandom_range(2, 4), -1);
        for (j = 0; j < 6; j++) send_frame(0, $urandom_range(0, pool_n - 1));
        drain();
    endtask

    task automatic test_random();
        int pick, j;
        while (items_sent < ITEMS_TOTAL) begin
            if ($urandom_range(0, 19) == 0) calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 70) random_frame();
            else if (pick < 80) begin
                for (j = 0; j < 4; j++) send(sldd_pkg::ACT_BYTE, $urandom_range(0, 3) == 0 ?
                                             8'h00 : 8'($urandom_range(0, 255)));
            end else if (pick < 88) send_header(8'($urandom_range(0, 255)));
            else if (pick < 95) begin
                send_header(8'($urandom_range(7, 21)));
                for (j = $urandom_range(0, 18); j > 0; j--)
                    send(sldd_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
                send(sldd_pkg::ACT_START, 8'($urandom_range(0, 255)));
            end else send(sldd_pkg::ACT_START, 8'($urandom_range(0, 255)));
        end
        calm = 0;
        drain();
    endtask

    always @(posedge aclk) begin : check_results
        frame_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) report("unexpected result", int'(m_event_res), -1);
            else begin
                e = expected_q.pop_front();
                if (m_event_res !== e.ev)
                    report("event_res", int'(m_event_res), int'(e.ev));
                if (m_payload_byte !== e.pb)
                    report("payload_byte", int'(m_payload_byte), int'(e.pb));
                if (m_payload_last !== e.last)
                    report("payload_last", int'(m_payload_last), int'(e.last));
                if (m_duplicate !== e.dup)
                    report("duplicate", int'(m_duplicate), int'(e.dup));
                if (m_tag_slot !== e.slot)
                    report("tag_slot", int'(m_tag_slot), int'(e.slot));
                if (m_table_full !== e.full)
                    report("table_full", int'(m_table_full), int'(e.full));
            end
        end
    end

    initial begin : result_sink
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            dog <= 0;
        else
            dog <= dog + 1;
        if (dog >= DOG_LIMIT) begin
            $display("tb_sync_length_frame_deframer_dedup_unit failed");
            $finish;
        end
    end

    initial begin
        min_len = 8;
        max_len = 22;
        seen_cnt = 0;
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_bounds();
        test_table_full();
        test_random();
        if (errors == 0)
            $display("tb_sync_length_frame_deframer_dedup_unit passed");
        else
            $display("tb_sync_length_frame_deframer_dedup_unit failed");
        $finish;
    end
endmodule
